/* hdl/bsg_pkg.sv */
// Shared types and constants of the bicubic sampler.
// Used by bsg_hstep and bicubic_sample_with_gradients_unit; no dependencies.
package bsg_pkg;

  localparam int PLANE_AW    = 16;
  localparam int PLANE_DEPTH = 1 << PLANE_AW;

  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;

  localparam int QW    = 25;
  localparam int QFRAC = 16;
  localparam int CI_W  = QW - 1 - QFRAC;

  localparam int CFRAC = 12;
  localparam int WW    = 63;
  localparam int OW    = 48;

  localparam int DEF_MAX_WIDTH   = 256;
  localparam int DEF_MAX_HEIGHT  = 256;
  localparam int DEF_SAMPLE_BITS = 24;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [CFG_W-1:0] SIZE_RESET = 9'd256;
  localparam logic [CFG_W-1:0] MIN_SIZE   = 9'd2;

  typedef logic signed [WW-1:0] wword_t;
  typedef logic signed [QW-1:0] qword_t;

  localparam wword_t W_MAX   = {1'b0, {(WW - 1){1'b1}}};
  localparam wword_t W_MIN   = {1'b1, {(WW - 1){1'b0}}};
  localparam wword_t OUT_MAX = {{(WW - OW + 1){1'b0}}, {(OW - 1){1'b1}}};
  localparam wword_t OUT_MIN = {{(WW - OW + 1){1'b1}}, {(OW - 1){1'b0}}};

  typedef struct packed {
    wword_t ca;
    wword_t cb;
    qword_t x;
  } hside_t;

endpackage

/* hdl/bsg_hstep.sv */
// One Horner step: y = sat(round(r * s / 2^16) + c), three register stages.
// Carries s and a sideband bundle along with the same latency. Uses bsg_pkg.
module bsg_hstep (
  input  logic             clk,
  input  bsg_pkg::wword_t  r,
  input  bsg_pkg::wword_t  c,
  input  bsg_pkg::qword_t  s,
  input  bsg_pkg::hside_t  side_in,
  output bsg_pkg::wword_t  y,
  output bsg_pkg::qword_t  s_out,
  output bsg_pkg::hside_t  side_out
);

  localparam int LO_W = 32;
  localparam int PL_W = LO_W + 1 + bsg_pkg::QW;
  localparam int PH_W = bsg_pkg::WW - LO_W + bsg_pkg::QW;
  localparam int RS_W = PH_W + bsg_pkg::QFRAC + 1;
  localparam logic signed [PL_W-1:0] HALF = PL_W'(1) <<< (bsg_pkg::QFRAC - 1);

  logic signed [PL_W-1:0]       pl;
  logic signed [PH_W-1:0]       ph;
  logic signed [PL_W-1:0]       pl_rnd;
  logic signed [RS_W-1:0]       rnd;
  logic signed [bsg_pkg::WW:0]  sum;
  bsg_pkg::wword_t              c1, c2, w2;
  bsg_pkg::qword_t              s1, s2;
  bsg_pkg::hside_t              side1, side2;

  always_comb begin
    pl_rnd = pl + HALF;
    rnd    = (RS_W'(ph) <<< bsg_pkg::QFRAC) + RS_W'(pl_rnd >>> bsg_pkg::QFRAC);
    sum    = (bsg_pkg::WW + 1)'(w2) + (bsg_pkg::WW + 1)'(c2);
  end

  always_ff @(posedge clk) begin
    pl    <= PL_W'($signed({1'b0, r[LO_W-1:0]})) * PL_W'(s);
    ph    <= PH_W'($signed(r[bsg_pkg::WW-1:LO_W])) * PH_W'(s);
    c1    <= c;
    s1    <= s;
    side1 <= side_in;

    if (rnd > RS_W'(bsg_pkg::W_MAX)) begin
      w2 <= bsg_pkg::W_MAX;
    end else if (rnd < RS_W'(bsg_pkg::W_MIN)) begin
      w2 <= bsg_pkg::W_MIN;
    end else begin
      w2 <= $signed(rnd[bsg_pkg::WW-1:0]);
    end
    c2    <= c1;
    s2    <= s1;
    side2 <= side1;

    if (sum > (bsg_pkg::WW + 1)'(bsg_pkg::W_MAX)) begin
      y <= bsg_pkg::W_MAX;
    end else if (sum < (bsg_pkg::WW + 1)'(bsg_pkg::W_MIN)) begin
      y <= bsg_pkg::W_MIN;
    end else begin
      y <= $signed(sum[bsg_pkg::WW-1:0]);
    end
    s_out    <= s2;
    side_out <= side2;
  end

endmodule

/* hdl/bicubic_sample_with_gradients_unit.sv */
// Bicubic Hermite sampler with x/y derivatives over four pixel planes.
// Depends on bsg_pkg and bsg_hstep.
//
// channel   signals                                        direction
// request   start, busy, req_type, pixel_addr,             in  (busy out)
//           intensity_in, grad_x_in, grad_y_in,
//           grad_xy_in, query_x, query_y
// config    cfg_write, cfg_index, cfg_data                  in
// result    done, value_out, deriv_x_out, deriv_y_out       out
//
// One request per cycle; busy stays low. A query's result strobes on done after these registers,
// in order: qx0/qy0, xi1/yi1 and the plane read rd (two copies, two read ports each, four
// pixels at once), tmp and coef for the coefficient math, six Horner steps of three stages
// each, then one output register. A write passes wa1/wd1 and wa2/wd2 before it lands in the
// planes, at the same pipeline point where queries read. Reset sets both sizes to 256;
// the planes are not cleared. The result side cannot stall.
module bicubic_sample_with_gradients_unit #(
  parameter int MAX_WIDTH   = bsg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = bsg_pkg::DEF_MAX_HEIGHT,
  parameter int SAMPLE_BITS = bsg_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cfg_write,
  input  logic [bsg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bsg_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                req_type,
  input  logic [bsg_pkg::PLANE_AW-1:0]        pixel_addr,
  input  logic signed [SAMPLE_BITS-1:0]       intensity_in,
  input  logic signed [SAMPLE_BITS-1:0]       grad_x_in,
  input  logic signed [SAMPLE_BITS-1:0]       grad_y_in,
  input  logic signed [SAMPLE_BITS-1:0]       grad_xy_in,
  input  logic signed [bsg_pkg::QW-1:0]       query_x,
  input  logic signed [bsg_pkg::QW-1:0]       query_y,
  output logic                                done,
  output logic signed [bsg_pkg::OW-1:0]       value_out,
  output logic signed [bsg_pkg::OW-1:0]       deriv_x_out,
  output logic signed [bsg_pkg::OW-1:0]       deriv_y_out
);

  localparam int PIPE_DEPTH = 23;
  localparam int ENT_W      = 4 * SAMPLE_BITS;
  localparam int CW         = SAMPLE_BITS + 10;
  localparam int OFF_F      = 3 * SAMPLE_BITS;
  localparam int OFF_GX     = 2 * SAMPLE_BITS;
  localparam int OFF_GY     = SAMPLE_BITS;
  localparam int OFF_GXY    = 0;
  localparam int RB_W       = bsg_pkg::CI_W + bsg_pkg::CFG_W;

  logic [bsg_pkg::CFG_W-1:0]      image_width, image_height;
  logic [bsg_pkg::CFG_W-1:0]      w_eff, h_eff, lim_x, lim_y;
  logic                           accept;
  logic [PIPE_DEPTH-1:0]          vpipe;
  logic                           wv1, wv2;
  logic [bsg_pkg::PLANE_AW-1:0]   wa1, wa2;
  logic [ENT_W-1:0]               wd1, wd2;

  bsg_pkg::qword_t                qx0, qy0;
  logic [bsg_pkg::CI_W-1:0]       xi, yi, xi1, yi1;
  bsg_pkg::qword_t                tq, uq, tq1, uq1, tq2, uq2, tq3, uq3, tq4, uq4;
  logic [RB_W-1:0]                row_base;
  logic [bsg_pkg::PLANE_AW-1:0]   addr00, addr10, addr01, addr11;

  logic [ENT_W-1:0]               mem_a [bsg_pkg::PLANE_DEPTH];
  logic [ENT_W-1:0]               mem_b [bsg_pkg::PLANE_DEPTH];
  logic [ENT_W-1:0]               rd [2][2];

  logic signed [CW-1:0]           fm [4][4];
  logic signed [CW-1:0]           tmp [4][4];
  logic signed [CW-1:0]           am [4][4];
  bsg_pkg::wword_t                coef [3][4][4];

  bsg_pkg::wword_t                st_r [3][4][3];
  bsg_pkg::wword_t                st_c [3][4][3];
  bsg_pkg::wword_t                st_y [3][4][3];
  bsg_pkg::qword_t                st_s [3][4][3];
  bsg_pkg::qword_t                st_so [3][4][3];
  bsg_pkg::hside_t                st_sd [3][4][3];
  bsg_pkg::hside_t                st_sdo [3][4][3];

  bsg_pkg::wword_t                ot_r [3][3];
  bsg_pkg::wword_t                ot_c [3][3];
  bsg_pkg::wword_t                ot_y [3][3];
  bsg_pkg::qword_t                ot_s [3][3];
  bsg_pkg::qword_t                ot_so [3][3];
  bsg_pkg::hside_t                ot_sd [3][3];
  bsg_pkg::hside_t                ot_sdo [3][3];

  function automatic logic signed [bsg_pkg::OW-1:0] to_out(input bsg_pkg::wword_t v);
    logic signed [bsg_pkg::OW-1:0] res;
    if (v > bsg_pkg::OUT_MAX) begin
      res = bsg_pkg::OUT_MAX[bsg_pkg::OW-1:0];
    end else if (v < bsg_pkg::OUT_MIN) begin
      res = bsg_pkg::OUT_MIN[bsg_pkg::OW-1:0];
    end else begin
      res = v[bsg_pkg::OW-1:0];
    end
    return res;
  endfunction

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    if (image_width < bsg_pkg::MIN_SIZE) begin
      w_eff = bsg_pkg::MIN_SIZE;
    end else if (int'(image_width) > MAX_WIDTH) begin
      w_eff = bsg_pkg::CFG_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (image_height < bsg_pkg::MIN_SIZE) begin
      h_eff = bsg_pkg::MIN_SIZE;
    end else if (int'(image_height) > MAX_HEIGHT) begin
      h_eff = bsg_pkg::CFG_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
    lim_x = w_eff - bsg_pkg::MIN_SIZE;
    lim_y = h_eff - bsg_pkg::MIN_SIZE;

    if (qx0[bsg_pkg::QW-1]) begin
      xi = '0;
    end else if ({1'b0, qx0[bsg_pkg::QW-2:bsg_pkg::QFRAC]} > lim_x) begin
      xi = lim_x[bsg_pkg::CI_W-1:0];
    end else begin
      xi = qx0[bsg_pkg::QW-2:bsg_pkg::QFRAC];
    end
    if (qy0[bsg_pkg::QW-1]) begin
      yi = '0;
    end else if ({1'b0, qy0[bsg_pkg::QW-2:bsg_pkg::QFRAC]} > lim_y) begin
      yi = lim_y[bsg_pkg::CI_W-1:0];
    end else begin
      yi = qy0[bsg_pkg::QW-2:bsg_pkg::QFRAC];
    end
    tq = qx0 - $signed({1'b0, xi, bsg_pkg::QFRAC'(0)});
    uq = qy0 - $signed({1'b0, yi, bsg_pkg::QFRAC'(0)});

    row_base = RB_W'(yi1) * RB_W'(w_eff);
    addr00   = bsg_pkg::PLANE_AW'(row_base) + bsg_pkg::PLANE_AW'(xi1);
    addr10   = addr00 + bsg_pkg::PLANE_AW'(1);
    addr01   = addr00 + bsg_pkg::PLANE_AW'(w_eff);
    addr11   = addr01 + bsg_pkg::PLANE_AW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bsg_pkg::SIZE_RESET;
      image_height <= bsg_pkg::SIZE_RESET;
      vpipe        <= '0;
      wv1          <= 1'b0;
      wv2          <= 1'b0;
      done         <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          bsg_pkg::REG_WIDTH:  image_width  <= cfg_data;
          bsg_pkg::REG_HEIGHT: image_height <= cfg_data;
        endcase
      end
      vpipe <= {vpipe[PIPE_DEPTH-2:0], accept && (req_type == bsg_pkg::REQ_QUERY)};
      wv1   <= accept && (req_type == bsg_pkg::REQ_WRITE);
      wv2   <= wv1;
      done  <= vpipe[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    wa1 <= pixel_addr;
    wd1 <= {intensity_in, grad_x_in, grad_y_in, grad_xy_in};
    wa2 <= wa1;
    wd2 <= wd1;
    qx0 <= query_x;
    qy0 <= query_y;
    xi1 <= xi;
    yi1 <= yi;
    tq1 <= tq;
    uq1 <= uq;
    tq2 <= tq1;
    uq2 <= uq1;
    tq3 <= tq2;
    uq3 <= uq2;
    tq4 <= tq3;
    uq4 <= uq3;
  end

  always_ff @(posedge clk) begin
    if (wv2) begin
      mem_a[wa2] <= wd2;
      mem_b[wa2] <= wd2;
    end
    rd[0][0] <= mem_a[addr00];
    rd[1][0] <= mem_a[addr10];
    rd[0][1] <= mem_b[addr01];
    rd[1][1] <= mem_b[addr11];
  end

  always_comb begin
    for (int x = 0; x < 2; x++) begin
      for (int y = 0; y < 2; y++) begin
        fm[x][y]         = CW'($signed(rd[x][y][OFF_F +: SAMPLE_BITS]));
        fm[x][y + 2]     = CW'($signed(rd[x][y][OFF_GY +: SAMPLE_BITS]));
        fm[x + 2][y]     = CW'($signed(rd[x][y][OFF_GX +: SAMPLE_BITS]));
        fm[x + 2][y + 2] = CW'($signed(rd[x][y][OFF_GXY +: SAMPLE_BITS]));
      end
    end
    for (int i = 0; i < 4; i++) begin
      am[i][0] = tmp[i][0];
      am[i][1] = tmp[i][2];
      am[i][2] = (((tmp[i][1] - tmp[i][0]) <<< 1) + (tmp[i][1] - tmp[i][0]))
                 - (tmp[i][2] <<< 1) - tmp[i][3];
      am[i][3] = ((tmp[i][0] - tmp[i][1]) <<< 1) + tmp[i][2] + tmp[i][3];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      tmp[0][j] <= fm[0][j];
      tmp[1][j] <= fm[2][j];
      tmp[2][j] <= (((fm[1][j] - fm[0][j]) <<< 1) + (fm[1][j] - fm[0][j]))
                   - (fm[2][j] <<< 1) - fm[3][j];
      tmp[3][j] <= ((fm[0][j] - fm[1][j]) <<< 1) + fm[2][j] + fm[3][j];
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        coef[0][i][j] <= bsg_pkg::WW'(am[i][j]) <<< bsg_pkg::CFRAC;
        if (i < 3) begin
          coef[1][i][j] <= bsg_pkg::WW'(am[i + 1][j] * CW'(i + 1)) <<< bsg_pkg::CFRAC;
        end else begin
          coef[1][i][j] <= '0;
        end
        if (j < 3) begin
          coef[2][i][j] <= bsg_pkg::WW'(am[i][j + 1] * CW'(j + 1)) <<< bsg_pkg::CFRAC;
        end else begin
          coef[2][i][j] <= '0;
        end
      end
    end
  end

  for (genvar e = 0; e < 3; e++) begin : g_eval
    for (genvar i = 0; i < 4; i++) begin : g_row
      for (genvar k = 0; k < 3; k++) begin : g_in
        if (k == 0) begin : g_first
          assign st_r[e][i][k]  = coef[e][i][3];
          assign st_c[e][i][k]  = coef[e][i][2];
          assign st_s[e][i][k]  = uq4;
          assign st_sd[e][i][k] = '{ca: coef[e][i][1], cb: coef[e][i][0], x: tq4};
        end else begin : g_next
          assign st_r[e][i][k]  = st_y[e][i][k-1];
          assign st_c[e][i][k]  = st_sdo[e][i][k-1].ca;
          assign st_s[e][i][k]  = st_so[e][i][k-1];
          assign st_sd[e][i][k] = '{ca: st_sdo[e][i][k-1].cb, cb: '0,
                                    x: st_sdo[e][i][k-1].x};
        end
        bsg_hstep u_step (
          .clk      (clk),
          .r        (st_r[e][i][k]),
          .c        (st_c[e][i][k]),
          .s        (st_s[e][i][k]),
          .side_in  (st_sd[e][i][k]),
          .y        (st_y[e][i][k]),
          .s_out    (st_so[e][i][k]),
          .side_out (st_sdo[e][i][k])
        );
      end
    end
    for (genvar k = 0; k < 3; k++) begin : g_out
      if (k == 0) begin : g_first
        assign ot_r[e][k]  = st_y[e][3][2];
        assign ot_c[e][k]  = st_y[e][2][2];
        assign ot_s[e][k]  = st_sdo[e][0][2].x;
        assign ot_sd[e][k] = '{ca: st_y[e][1][2], cb: st_y[e][0][2],
                               x: st_sdo[e][0][2].x};
      end else begin : g_next
        assign ot_r[e][k]  = ot_y[e][k-1];
        assign ot_c[e][k]  = ot_sdo[e][k-1].ca;
        assign ot_s[e][k]  = ot_so[e][k-1];
        assign ot_sd[e][k] = '{ca: ot_sdo[e][k-1].cb, cb: '0, x: ot_sdo[e][k-1].x};
      end
      bsg_hstep u_step (
        .clk      (clk),
        .r        (ot_r[e][k]),
        .c        (ot_c[e][k]),
        .s        (ot_s[e][k]),
        .side_in  (ot_sd[e][k]),
        .y        (ot_y[e][k]),
        .s_out    (ot_so[e][k]),
        .side_out (ot_sdo[e][k])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (vpipe[PIPE_DEPTH-1]) begin
      value_out   <= to_out(ot_y[0][2]);
      deriv_x_out <= to_out(ot_y[1][2]);
      deriv_y_out <= to_out(ot_y[2][2]);
    end
  end

  a_query_answered: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == bsg_pkg::REQ_QUERY) |-> ##(PIPE_DEPTH + 1) done)
    else $error("query transfer not answered on time");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == bsg_pkg::REQ_WRITE) |-> ##(PIPE_DEPTH + 1) !done)
    else $error("write transfer produced a result");

  a_no_plane_clash: assert property (@(posedge clk) disable iff (rst)
    !(wv2 && vpipe[1]))
    else $error("plane write and query read in the same cycle");

endmodule
